### sv/ipv4fwd_pkg.sv
// ----------------------------------------------------------------------------
// ipv4fwd_pkg
// Shared constants, result codes and controller/datapath interface types for
// the IPv4 forwarding engine.
// ----------------------------------------------------------------------------
package ipv4fwd_pkg;

  localparam int ROUTE_ENTRIES = 64;
  localparam int IDX_W         = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int COUNT_W       = $clog2(ROUTE_ENTRIES + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(ROUTE_ENTRIES);

  localparam logic REQ_FORWARD = 1'b0;
  localparam logic REQ_ADD     = 1'b1;

  localparam logic [2:0] ACT_FORWARD  = 3'd0;
  localparam logic [2:0] ACT_LOCAL    = 3'd1;
  localparam logic [2:0] ACT_NO_ROUTE = 3'd2;
  localparam logic [2:0] ACT_TTL      = 3'd3;
  localparam logic [2:0] ACT_STORED   = 3'd4;
  localparam logic [2:0] ACT_FULL     = 3'd5;

  localparam logic [15:0] CSUM_INC = 16'h0100;

  typedef struct packed {
    logic load;
    logic scan;
    logic exec;
    logic emit;
  } fwd_cmd_t;

  typedef struct packed {
    logic scan_done;
  } fwd_status_t;

endpackage

### sv/ipv4fwd_ctrl.sv
// ----------------------------------------------------------------------------
// ipv4fwd_ctrl
// Sequencer for one request word: load, table scan, table update or next hop
// read, then result emit.
// ----------------------------------------------------------------------------
module ipv4fwd_ctrl
  import ipv4fwd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  fwd_status_t status,
  output fwd_cmd_t    cmd,
  output logic        busy
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_RESP;
      end
      ST_RESP: begin
        cmd.emit   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

### sv/ipv4fwd_dp.sv
// ----------------------------------------------------------------------------
// ipv4fwd_dp
// Datapath: request registers, route memories with a linear exact-match scan,
// route insert/update, TTL and checksum update and the result register.
// ----------------------------------------------------------------------------
module ipv4fwd_dp
  import ipv4fwd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  fwd_cmd_t    cmd,
  output fwd_status_t status,
  input  logic        req_type,
  input  logic [31:0] dest_ip,
  input  logic [31:0] next_hop,
  input  logic [7:0]  ttl_in,
  input  logic [15:0] checksum_in,
  input  logic        local_addr_valid,
  output logic        local_addr_ready,
  input  logic [31:0] local_addr,
  output logic        done,
  output logic [2:0]  action,
  output logic [31:0] next_hop_out,
  output logic [7:0]  ttl_out,
  output logic [15:0] checksum_out
);

  logic [31:0] dest_mem [ROUTE_ENTRIES];
  logic [31:0] hop_mem  [ROUTE_ENTRIES];

  logic              req_type_r;
  logic [31:0]       dest_r;
  logic [31:0]       hop_r;
  logic [7:0]        ttl_r;
  logic [15:0]       csum_r;
  logic [31:0]       router_addr;
  logic [COUNT_W-1:0] route_count;
  logic [COUNT_W-1:0] scan_addr;
  logic              rd_valid;
  logic [31:0]       rd_dest;
  logic [IDX_W-1:0]  rd_idx;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  logic [31:0]       rd_hop;
  logic              full;

  logic              issue;
  logic              match;
  logic              add_new;
  logic              hop_we;
  logic [IDX_W-1:0]  hop_idx;
  logic [16:0]       sum_wide;
  logic [15:0]       csum_next;

  assign local_addr_ready = 1'b1;

  // scan control
  assign issue = cmd.scan && !hit && (scan_addr < route_count);
  assign match = rd_valid && (rd_dest == dest_r);
  assign status.scan_done = hit || (!rd_valid && (scan_addr >= route_count));

  // table update
  assign add_new = cmd.exec && (req_type_r == REQ_ADD) && !hit && (route_count < COUNT_MAX);
  assign hop_we  = (cmd.exec && (req_type_r == REQ_ADD) && hit) || add_new;
  assign hop_idx = hit ? hit_idx : route_count[IDX_W-1:0];

  // one's complement add with end-around carry
  assign sum_wide  = {1'b0, csum_r} + {1'b0, CSUM_INC};
  assign csum_next = sum_wide[15:0] + {15'd0, sum_wide[16]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_r <= req_type;
      dest_r     <= dest_ip;
      hop_r      <= next_hop;
      ttl_r      <= ttl_in;
      csum_r     <= checksum_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      router_addr <= '0;
    end else if (local_addr_valid && local_addr_ready) begin
      router_addr <= local_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_dest <= dest_mem[scan_addr[IDX_W-1:0]];
      rd_idx  <= scan_addr[IDX_W-1:0];
    end
    if (add_new) begin
      dest_mem[route_count[IDX_W-1:0]] <= dest_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_hop <= hop_mem[hit_idx];
    end
    if (hop_we) begin
      hop_mem[hop_idx] <= hop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      rd_valid  <= 1'b0;
      hit       <= 1'b0;
    end else if (cmd.load) begin
      scan_addr <= '0;
      rd_valid  <= 1'b0;
      hit       <= 1'b0;
    end else begin
      rd_valid <= issue;
      if (issue) begin
        scan_addr <= scan_addr + COUNT_W'(1);
      end
      if (match && !hit) begin
        hit     <= 1'b1;
        hit_idx <= rd_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      route_count <= '0;
    end else if (add_new) begin
      route_count <= route_count + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      full <= !hit && (route_count == COUNT_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      next_hop_out <= '0;
      ttl_out      <= '0;
      checksum_out <= '0;
      if (req_type_r == REQ_ADD) begin
        action <= full ? ACT_FULL : ACT_STORED;
      end else if (!hit) begin
        action <= ACT_NO_ROUTE;
      end else if (ttl_r <= 8'd1) begin
        action <= ACT_TTL;
      end else begin
        action       <= (dest_r == router_addr) ? ACT_LOCAL : ACT_FORWARD;
        next_hop_out <= rd_hop;
        ttl_out      <= ttl_r - 8'd1;
        checksum_out <= csum_next;
      end
    end
  end

endmodule

### sv/ipv4_forward_with_route_table.sv
// ----------------------------------------------------------------------------
// ipv4_forward_with_route_table
// IPv4 forwarding engine with an exact-match route table: route add and
// header forward decision with TTL decrement and checksum update.
//
//   channel     handshake                      word
//   request     start / busy                   req_type, dest_ip, next_hop,
//                                              ttl_in, checksum_in
//   result      done (one-cycle strobe)        action, next_hop_out, ttl_out,
//                                              checksum_out
//   local addr  local_addr_valid / _ready      local_addr
//
// the route memory is scanned one entry per cycle up to the first match or
// the fill count
// done is high in the first cycle that busy is low; a new request may start
// that cycle
// reset clears the fill count, so the route memories need no clearing pass
// the receiver cannot stall; the result is valid for the done cycle only
// ----------------------------------------------------------------------------
module ipv4_forward_with_route_table
  import ipv4fwd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [31:0] dest_ip,
  input  logic [31:0] next_hop,
  input  logic [7:0]  ttl_in,
  input  logic [15:0] checksum_in,
  input  logic        local_addr_valid,
  output logic        local_addr_ready,
  input  logic [31:0] local_addr,
  output logic        done,
  output logic [2:0]  action,
  output logic [31:0] next_hop_out,
  output logic [7:0]  ttl_out,
  output logic [15:0] checksum_out
);

  fwd_cmd_t    cmd;
  fwd_status_t status;

  ipv4fwd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  ipv4fwd_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .req_type         (req_type),
    .dest_ip          (dest_ip),
    .next_hop         (next_hop),
    .ttl_in           (ttl_in),
    .checksum_in      (checksum_in),
    .local_addr_valid (local_addr_valid),
    .local_addr_ready (local_addr_ready),
    .local_addr       (local_addr),
    .done             (done),
    .action           (action),
    .next_hop_out     (next_hop_out),
    .ttl_out          (ttl_out),
    .checksum_out     (checksum_out)
  );

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_done_after_emit: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(cmd.emit) && !busy))
    else $error("result strobe without emit");

  a_action_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (action <= ACT_FULL))
    else $error("undefined action code");

  a_fwd_ttl: assert property (@(posedge clk) disable iff (rst)
    (done && (action == ACT_FORWARD || action == ACT_LOCAL)) |-> (ttl_out != 8'd0))
    else $error("forwarded header with zero ttl");

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IPv4 forwarding engine. A scoreboard keeps its
// own copy of the route table and local address and predicts the decision for
// each accepted request. Requests come from a short directed set, then random
// phases with the local address changed between them. The requests reuse
// known destinations so that lookups hit, and the table fills up.
// ----------------------------------------------------------------------------
module tb_top
  import ipv4fwd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        req;
    logic [31:0] dest;
    logic [31:0] hop;
    logic [7:0]  ttl;
    logic [15:0] csum;
  } fwd_req_t;

  typedef struct {
    logic [2:0]  act;
    logic [31:0] hop;
    logic [7:0]  ttl;
    logic [15:0] csum;
  } fwd_decision_t;

  class fwd_decision_checker;
    logic [31:0]   route_dest [ROUTE_ENTRIES];
    logic [31:0]   route_hop [ROUTE_ENTRIES];
    bit            route_used [ROUTE_ENTRIES];
    int            route_fill = 0;
    logic [31:0]   own_addr = '0;
    fwd_decision_t pending[$];
    int            n_requests = 0;
    int            n_checked = 0;
    int            n_mismatch = 0;
    int            act_count [6];

    function void set_local(logic [31:0] a);
      own_addr = a;
    endfunction

    function fwd_decision_t predict_decision(fwd_req_t r);
      fwd_decision_t d;
      int            slot;
      logic [16:0]   sum;
      d.act  = ACT_NO_ROUTE;
      d.hop  = '0;
      d.ttl  = '0;
      d.csum = '0;
      slot   = -1;
      for (int i = 0; i < ROUTE_ENTRIES; i++) begin
        if (slot < 0 && route_used[i] && route_dest[i] == r.dest) slot = i;
      end
      if (r.req == REQ_ADD) begin
        d.act = ACT_STORED;
        if (slot >= 0) begin
          route_hop[slot] = r.hop;
        end else if (route_fill < ROUTE_ENTRIES) begin
          route_dest[route_fill] = r.dest;
          route_hop[route_fill]  = r.hop;
          route_used[route_fill] = 1'b1;
          route_fill++;
        end else begin
          d.act = ACT_FULL;
        end
      end else if (slot < 0) begin
        d.act = ACT_NO_ROUTE;
      end else if (r.ttl <= 8'd1) begin
        d.act = ACT_TTL;
      end else begin
        // one's complement add with end-around carry
        sum    = {1'b0, r.csum} + {1'b0, CSUM_INC};
        d.csum = sum[16] ? sum[15:0] + 16'd1 : sum[15:0];
        d.ttl  = r.ttl - 8'd1;
        d.hop  = route_hop[slot];
        d.act  = (r.dest == own_addr) ? ACT_LOCAL : ACT_FORWARD;
      end
      return d;
    endfunction

    function void note_request(fwd_req_t r);
      n_requests++;
      pending.push_back(predict_decision(r));
    endfunction

    function void flag(string what, fwd_decision_t want, fwd_decision_t got);
      n_mismatch++;
      if (n_mismatch <= 10)
        $display({"%0t %s: expected act %0d hop %h ttl %h csum %h, ",
                  "got act %0d hop %h ttl %h csum %h"},
                 $time, what, want.act, want.hop, want.ttl, want.csum,
                 got.act, got.hop, got.ttl, got.csum);
    endfunction

    function void check_decision(fwd_decision_t got);
      fwd_decision_t want;
      n_checked++;
      if (pending.size() == 0) begin
        want.act  = 'x;
        want.hop  = 'x;
        want.ttl  = 'x;
        want.csum = 'x;
        flag("unexpected result", want, got);
        return;
      end
      want = pending.pop_front();
      if (want.act <= ACT_FULL) act_count[want.act]++;
      if (got.act !== want.act || got.hop !== want.hop || got.ttl !== want.ttl ||
          got.csum !== want.csum)
        flag("mismatch", want, got);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        req_type;
  logic [31:0] dest_ip;
  logic [31:0] next_hop;
  logic [7:0]  ttl_in;
  logic [15:0] checksum_in;
  logic        local_addr_valid;
  logic        local_addr_ready;
  logic [31:0] local_addr;
  logic        done;
  logic [2:0]  action;
  logic [31:0] next_hop_out;
  logic [7:0]  ttl_out;
  logic [15:0] checksum_out;

  fwd_decision_checker chk = new;
  logic [31:0]         known_dests[$];
  int                  burst_left = 0;

  ipv4_forward_with_route_table u_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .req_type         (req_type),
    .dest_ip          (dest_ip),
    .next_hop         (next_hop),
    .ttl_in           (ttl_in),
    .checksum_in      (checksum_in),
    .local_addr_valid (local_addr_valid),
    .local_addr_ready (local_addr_ready),
    .local_addr       (local_addr),
    .done             (done),
    .action           (action),
    .next_hop_out     (next_hop_out),
    .ttl_out          (ttl_out),
    .checksum_out     (checksum_out)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", chk.pending.size());
    $display("tb_top failed");
    $finish;
  end

  // observe accepted words on every channel
  always @(posedge clk) begin
    fwd_decision_t got;
    fwd_req_t      r;
    if (!rst) begin
      if (done) begin
        got.act  = action;
        got.hop  = next_hop_out;
        got.ttl  = ttl_out;
        got.csum = checksum_out;
        chk.check_decision(got);
      end
      if (start && !busy) begin
        r.req  = req_type;
        r.dest = dest_ip;
        r.hop  = next_hop;
        r.ttl  = ttl_in;
        r.csum = checksum_in;
        chk.note_request(r);
      end
      if (local_addr_valid && local_addr_ready) chk.set_local(local_addr);
    end
  end

  task automatic send_request(input fwd_req_t r);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(15, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    req_type    <= r.req;
    dest_ip     <= r.dest;
    next_hop    <= r.hop;
    ttl_in      <= r.ttl;
    checksum_in <= r.csum;
    do @(posedge clk); while (busy);
  endtask

  task automatic send(input logic req, input logic [31:0] dest, input logic [31:0] hop,
                      input logic [7:0] ttl, input logic [15:0] csum);
    fwd_req_t r;
    r.req  = req;
    r.dest = dest;
    r.hop  = hop;
    r.ttl  = ttl;
    r.csum = csum;
    send_request(r);
  endtask

  // advance the clock first so the monitor has noted the last accepted request
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (chk.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_local(input logic [31:0] a);
    wait_drained();
    local_addr_valid <= 1'b1;
    local_addr       <= a;
    do @(posedge clk); while (!local_addr_ready);
    local_addr_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_known();
    return known_dests[$urandom_range(0, known_dests.size() - 1)];
  endfunction

  function automatic fwd_req_t random_request(int add_pct);
    fwd_req_t r;
    int       pick;
    r.req  = ($urandom_range(0, 99) < add_pct) ? REQ_ADD : REQ_FORWARD;
    r.dest = $urandom();
    r.hop  = $urandom();
    r.ttl  = 8'($urandom());
    r.csum = 16'($urandom());
    pick   = $urandom_range(0, 99);
    if (r.req == REQ_ADD) begin
      if (pick < 50 && known_dests.size() > 0) r.dest = pick_known();
      else known_dests.push_back(r.dest);
    end else begin
      if (pick < 70 && known_dests.size() > 0) r.dest = pick_known();
      else if (pick < 80) r.dest = chk.own_addr;
    end
    pick = $urandom_range(0, 99);
    if (pick < 8) r.ttl = 8'd0;
    else if (pick < 16) r.ttl = 8'd1;
    else if (pick < 24) r.ttl = 8'hff;
    else if (pick < 28) r.ttl = 8'd2;
    pick = $urandom_range(0, 99);
    if (pick < 10) r.csum = 16'hffff;
    else if (pick < 15) r.csum = 16'hfeff;
    else if (pick < 20) r.csum = 16'hff00;
    else if (pick < 25) r.csum = 16'h0000;
    return r;
  endfunction

  task automatic run_phase(input int count, input int add_pct);
    for (int i = 0; i < count; i++) send_request(random_request(add_pct));
  endtask

  initial begin
    rst              <= 1'b1;
    start            <= 1'b0;
    req_type         <= REQ_FORWARD;
    dest_ip          <= '0;
    next_hop         <= '0;
    ttl_in           <= '0;
    checksum_in      <= '0;
    local_addr_valid <= 1'b0;
    local_addr       <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, ttl expiry, checksum wrap, re-add, local delivery
    write_local(32'hffff_ffff);
    send(REQ_FORWARD, 32'h0000_0000, 32'h0,          8'd64,  16'h1234);
    send(REQ_ADD,     32'h0000_0000, 32'hffff_ffff,  8'd0,   16'h0);
    send(REQ_ADD,     32'hffff_ffff, 32'h0000_0000,  8'hff,  16'hffff);
    send(REQ_ADD,     32'h1234_5678, 32'ha5a5_a5a5,  8'd7,   16'h0);
    send(REQ_FORWARD, 32'h0000_0000, 32'h0,          8'd0,   16'h0000);
    send(REQ_FORWARD, 32'h0000_0000, 32'h0,          8'd1,   16'h4321);
    send(REQ_FORWARD, 32'h0000_0000, 32'h0,          8'd2,   16'hffff);
    send(REQ_FORWARD, 32'h0000_0000, 32'hffff_ffff,  8'hff,  16'hfeff);
    send(REQ_FORWARD, 32'h0000_0000, 32'h0,          8'd128, 16'hff00);
    send(REQ_FORWARD, 32'h0000_0000, 32'h0,          8'd64,  16'h0000);
    send(REQ_FORWARD, 32'hffff_ffff, 32'h0,          8'hff,  16'h1234);
    send(REQ_FORWARD, 32'hffff_ffff, 32'h0,          8'd1,   16'h1234);
    send(REQ_FORWARD, 32'h1234_5678, 32'h0,          8'd2,   16'h00ff);
    send(REQ_FORWARD, 32'h1234_5679, 32'h0,          8'd99,  16'h0);
    send(REQ_ADD,     32'h0000_0000, 32'h0000_0000,  8'd5,   16'h5);
    send(REQ_FORWARD, 32'h0000_0000, 32'h0,          8'd10,  16'h8000);
    send(REQ_ADD,     32'h1234_5678, 32'hffff_ffff,  8'd0,   16'h0);
    send(REQ_FORWARD, 32'h1234_5678, 32'h0,          8'hff,  16'hffff);
    known_dests.push_back(32'h0000_0000);
    known_dests.push_back(32'hffff_ffff);
    known_dests.push_back(32'h1234_5678);

    // random phases, local address changed while idle
    write_local(32'h0000_0000);
    run_phase(283, 40);
    write_local(pick_known());
    run_phase(283, 30);
    write_local($urandom());
    run_phase(283, 20);
    write_local(pick_known());
    run_phase(283, 20);

    wait_drained();
    repeat (ROUTE_ENTRIES + 10) @(posedge clk);

    $display("%0d requests, %0d results checked, %0d routes in table",
             chk.n_requests, chk.n_checked, chk.route_fill);
    $display("fwd %0d local %0d no-route %0d ttl %0d stored %0d full %0d",
             chk.act_count[ACT_FORWARD], chk.act_count[ACT_LOCAL],
             chk.act_count[ACT_NO_ROUTE], chk.act_count[ACT_TTL],
             chk.act_count[ACT_STORED], chk.act_count[ACT_FULL]);
    if (chk.n_mismatch == 0 && chk.pending.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("%0d mismatches, %0d results missing", chk.n_mismatch, chk.pending.size());
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
